// ===== src/mhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 7;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [CSR_AW-1:0]  ADDR_CAPACITY  = 3'd0;
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_LAST,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== src/mhpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port RAM, registered read
module mhpq_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== src/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Insert: the word enters at the new last position and climbs, one parent read and compare
// per level, until its parent is not smaller or it reaches the root; remove: the last entry
// moves to the root and sinks, reading left then right child per level, and a remove that
// empties the heap writes nothing; a refused word goes straight to the result strobe. One
// command at a time: busy until the strobe cycle ends, and the receiver cannot stall.
// Synchronous reset empties the heap (count to zero), limit back to 64; RAM not cleared.
module max_heap_priority_queue #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // command side
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_cmd,
   input  wire logic signed [mhpq_pkg::WORD_W-1:0] req_value,
   // result side
   output logic                               rsp_valid,
   output logic                               rsp_accepted,
   output logic signed [mhpq_pkg::WORD_W-1:0] rsp_top_value,
   output logic        [mhpq_pkg::COUNT_W-1:0] rsp_entry_count,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic   [mhpq_pkg::CSR_AW-1:0] paddr,
   input  wire logic   [mhpq_pkg::CSR_DW-1:0] pwdata,
   output logic        [mhpq_pkg::CSR_DW-1:0] prdata,
   output logic                               pready
);

   import mhpq_pkg::*;

   // positions run 1..MAX_ENTRIES, RAM index is position - 1
   localparam int PW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LW = (PW > COUNT_W) ? PW : COUNT_W;
   localparam logic [LW-1:0] MAX_EXT = LW'(MAX_ENTRIES);

   // ---------------------------------------------------------------- registers
   state_type             state_ff, state_in;
   logic [PW-1:0]         count_ff, count_in;     // fill count
   logic [PW-1:0]         pos_ff, pos_in;         // current hole
   logic signed [WORD_W-1:0] val_ff, val_in;      // word being sifted
   logic signed [WORD_W-1:0] lval_ff, lval_in;    // left child during sift-down
   logic                  has_r_ff, has_r_in;     // right child exists
   logic signed [WORD_W-1:0] top_ff, top_in;      // mirror of position 1
   logic                  acc_ff, acc_in;
   logic [COUNT_W-1:0]    cap_ff, cap_in;

   // ---------------------------------------------------------------- RAM port
   logic                  ram_we;
   logic [IW-1:0]         ram_waddr;
   logic [WORD_W-1:0]     ram_wdata;
   logic [IW-1:0]         ram_raddr;
   logic [WORD_W-1:0]     ram_rdata;

   // Reads target the last entry (when idle) or the parent or children of the hole,
   // writes only the hole, so a read and a write never meet on one entry: no forwarding.
   mhpq_ram #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (IW),
      .DATA_W (WORD_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------- helpers
   logic                  cmd_take;
   logic [LW-1:0]         cap_ext, limit, count_ext;
   logic                  can_insert;
   logic [PW-1:0]         pos_m1, parent, parent_m1, count_m1, count_p1;
   logic [PW:0]           left, left_m1, right, count_wide;
   logic                  left_ok, right_ok;
   logic signed [WORD_W-1:0] rd_s;
   logic                  l_gt, r_gt;
   logic signed [WORD_W-1:0] lbest;
   logic                  csr_wr;

   assign cmd_take   = start && (state_ff == ST_IDLE);
   assign cap_ext    = LW'(cap_ff);
   assign count_ext  = LW'(count_ff);
   // effective limit is the smaller of the register and the store depth
   assign limit      = (cap_ext < MAX_EXT) ? cap_ext : MAX_EXT;
   assign can_insert = count_ext < limit;

   assign pos_m1     = pos_ff - PW'(1);
   assign parent     = pos_ff >> 1;
   assign parent_m1  = parent - PW'(1);
   assign count_m1   = count_ff - PW'(1);
   assign count_p1   = count_ff + PW'(1);
   assign left       = {pos_ff, 1'b0};
   assign left_m1    = left - (PW+1)'(1);
   assign right      = left + (PW+1)'(1);
   assign count_wide = {1'b0, count_ff};
   assign left_ok    = left <= count_wide;
   assign right_ok   = right <= count_wide;

   assign rd_s  = $signed(ram_rdata);
   // left wins a tie between children; equality stops the sift
   assign l_gt  = lval_ff > val_ff;
   assign lbest = l_gt ? lval_ff : val_ff;
   assign r_gt  = has_r_ff && (rd_s > lbest);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_INSERT) begin
                  state_in = can_insert ? ST_UP_RD : ST_RESP;
               end else begin
                  state_in = (count_ff != '0) ? ST_DN_LAST : ST_RESP;
               end
            end
         end
         ST_UP_RD: begin
            state_in = (pos_ff == PW'(1)) ? ST_RESP : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = (val_ff > rd_s) ? ST_UP_RD : ST_RESP;
         end
         ST_DN_LAST: begin
            state_in = (count_ff == '0) ? ST_RESP : ST_DN_RDL;
         end
         ST_DN_RDL: begin
            state_in = left_ok ? ST_DN_RDR : ST_RESP;
         end
         ST_DN_RDR: begin
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            state_in = (l_gt || r_gt) ? ST_DN_RDL : ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      lval_in   = lval_ff;
      has_r_in  = has_r_ff;
      acc_in    = acc_ff;
      ram_we    = 1'b0;
      ram_waddr = pos_m1[IW-1:0];
      ram_wdata = val_ff;
      ram_raddr = parent_m1[IW-1:0];
      case (state_ff)
         ST_IDLE: begin
            ram_raddr = count_m1[IW-1:0];   // last entry, for a remove
            if (start) begin
               val_in = req_value;
               if (req_cmd == CMD_INSERT) begin
                  acc_in = can_insert;
                  if (can_insert) begin
                     count_in = count_p1;
                     pos_in   = count_p1;
                  end
               end else begin
                  acc_in = count_ff != '0;
                  if (count_ff != '0) begin
                     count_in = count_m1;
                  end
               end
            end
         end
         ST_UP_RD: begin
            ram_raddr = parent_m1[IW-1:0];
            if (pos_ff == PW'(1)) begin
               ram_we = 1'b1;
            end
         end
         ST_UP_CMP: begin
            ram_we = 1'b1;
            if (val_ff > rd_s) begin
               ram_wdata = ram_rdata;       // parent drops into the hole
               pos_in    = parent;
            end
         end
         ST_DN_LAST: begin
            val_in = rd_s;
            pos_in = PW'(1);
         end
         ST_DN_RDL: begin
            ram_raddr = left_m1[IW-1:0];
            if (!left_ok) begin
               ram_we = 1'b1;
            end
         end
         ST_DN_RDR: begin
            lval_in   = rd_s;
            has_r_in  = right_ok;
            ram_raddr = left[IW-1:0];       // right - 1
         end
         ST_DN_CMP: begin
            ram_we = 1'b1;
            if (r_gt) begin
               ram_wdata = ram_rdata;
               pos_in    = right[PW-1:0];
            end else if (l_gt) begin
               ram_wdata = lval_ff;
               pos_in    = left[PW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // root mirror follows every write to position 1
   always_comb begin
      top_in = top_ff;
      if (ram_we && (pos_ff == PW'(1))) begin
         top_in = $signed(ram_wdata);
      end
   end

   // ---------------------------------------------------------------- register port
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr && (paddr == ADDR_CAPACITY)) begin
         cap_in = pwdata[COUNT_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_CAPACITY) ? CSR_DW'(cap_ff) : '0;

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         acc_ff   <= 1'b0;
         cap_ff   <= CAPACITY_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      lval_ff  <= lval_in;
      has_r_ff <= has_r_in;
      top_ff   <= top_in;
   end

   // ---------------------------------------------------------------- outputs
   logic [LW-1:0] count_out;

   always_comb begin
      count_out       = LW'(count_ff);
      busy            = state_ff != ST_IDLE;
      rsp_valid       = state_ff == ST_RESP;
      rsp_accepted    = acc_ff;
      rsp_top_value   = (count_ff == '0) ? '0 : top_ff;
      rsp_entry_count = count_out[COUNT_W-1:0];
   end

   // ---------------------------------------------------------------- checks
   a_resp_one_cycle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |=> (state_ff == ST_IDLE))
      else $error("result strobe longer than one cycle");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= PW'(MAX_ENTRIES))
      else $error("fill count beyond store depth");

   a_reject_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (count_ff == $past(count_ff)))
      else $error("refused word changed the fill count");

   a_take_goes_busy : assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> busy)
      else $error("command taken but block not busy");

   a_write_in_sift : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_UP_RD || state_ff == ST_UP_CMP ||
                  state_ff == ST_DN_RDL || state_ff == ST_DN_CMP))
      else $error("heap RAM written outside a sift step");

endmodule

`default_nettype wire
